@@ src/radial_bias_correction_macros.svh @@
// ----------------------------------------------------------------------------
// Radial bias correction assertion macros
// Concurrent assertion wrappers shared by the block's modules.
// ----------------------------------------------------------------------------
`ifndef RADIAL_BIAS_CORRECTION_MACROS_SVH
`define RADIAL_BIAS_CORRECTION_MACROS_SVH

`ifndef ASSERT_OFF
// Assertion that is switched off while reset is held.
`define RBC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assertion that is checked during reset as well.
`define RBC_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RBC_ASSERT(lbl, clk, rst_n, prop, msg)
`define RBC_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

@@ src/rbc_pkg.sv @@
// ----------------------------------------------------------------------------
// Radial bias correction package
// Widths, register codes and pipeline item types shared by the block.
// ----------------------------------------------------------------------------
package rbc_pkg;

    localparam int COORD_BITS     = 12;
    localparam int GAIN_FRAC_BITS = 12;
    localparam int PIX_W          = 8;
    localparam int GAIN_W         = 16;
    localparam int ROOT_FRAC      = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    // Squared distance and the radicand of the radius with its fraction bits.
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int D2_W   = SQ_W + 1;
    localparam int X_W    = D2_W + 2 * ROOT_FRAC;
    localparam int ROOT_W = (X_W + 1) / 2;
    localparam int PAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    // Multiplier operand is the radius or the squared distance.
    localparam int OP_W   = (D2_W > ROOT_W) ? D2_W : ROOT_W;
    localparam int PROD_W = GAIN_W + OP_W + 1;

    localparam int SH_LIN = GAIN_FRAC_BITS + ROOT_FRAC;
    localparam int SH_PAR = GAIN_FRAC_BITS;
    localparam int SHL_W  = PIX_W + SH_LIN + 1;
    localparam int V_W    = ((PROD_W > SHL_W) ? PROD_W : SHL_W) + 1;

    localparam logic [PIX_W-1:0] PIX_MAX = PIX_W'(255);

    localparam logic signed [V_W-1:0] FULL_LIN = V_W'(255) << SH_LIN;
    localparam logic signed [V_W-1:0] FULL_PAR = V_W'(255) << SH_PAR;
    localparam logic signed [V_W-1:0] HALF_LIN = V_W'(1) << (SH_LIN - 1);
    localparam logic signed [V_W-1:0] HALF_PAR = V_W'(1) << (SH_PAR - 1);

    localparam logic [D2_W-1:0] D2_MAX =
        D2_W'(2) * D2_W'((2 ** COORD_BITS) - 1) * D2_W'((2 ** COORD_BITS) - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN = 2'd0,
        REG_MODE = 2'd1,
        REG_CCOL = 2'd2,
        REG_CROW = 2'd3
    } t_reg_idx;

    typedef enum logic {
        MODE_LINEAR    = 1'b0,
        MODE_PARABOLIC = 1'b1
    } t_mode;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [D2_W-1:0]  d2;
    } t_dist_item;

    typedef struct packed {
        logic [PIX_W-1:0]  pix;
        logic [D2_W-1:0]   d2;
        logic [ROOT_W-1:0] root;
    } t_root_item;

endpackage

@@ src/rbc_ifs.sv @@
// ----------------------------------------------------------------------------
// Radial bias correction channel interfaces
// Pixel input, corrected pixel output and register write channels.
// ----------------------------------------------------------------------------
interface rbc_pix_if;
    logic                              valid;
    logic                              ready;
    logic [rbc_pkg::PIX_W-1:0]         pixel_in;
    logic [rbc_pkg::COORD_BITS-1:0]    col;
    logic [rbc_pkg::COORD_BITS-1:0]    row;

    modport source (output valid, output pixel_in, output col, output row, input ready);
    modport sink   (input valid, input pixel_in, input col, input row, output ready);
endinterface

interface rbc_res_if;
    logic                      valid;
    logic                      ready;
    logic [rbc_pkg::PIX_W-1:0] pixel_out;
    logic                      clipped;

    modport source (output valid, output pixel_out, output clipped, input ready);
    modport sink   (input valid, input pixel_out, input clipped, output ready);
endinterface

interface rbc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rbc_pkg::CFG_IDX_W-1:0]  index;
    logic [rbc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/radial_bias_correction.sv @@
// ----------------------------------------------------------------------------
// Radial bias correction
// Subtracts a radial bias, linear or parabolic in the distance from a centre.
// ----------------------------------------------------------------------------
// Usage: pixels enter on i_pix with their column and row; each transfer yields
// exactly one corrected pixel with a clip flag on o_res, in order.
// Registers are written on i_cfg (gain, mode, centre column, centre row) and
// are to be changed only while no pixel is in flight; i_cfg.ready is always
// high.
// Pipeline: 6 + COORD_BITS + 9 register stages, 27 with 12-bit coordinates;
// three stages form the squared distance, one per radius bit forms the square
// root, three scale, round and saturate.
// Throughput: one pixel per clock. The pipeline moves as a whole; it stops
// only while o_res holds a pixel that is not taken, and then i_pix.ready is
// low, so a stalled receiver loses and repeats nothing.
// Reset: synchronous, active low; it empties the pipeline and sets all
// registers to zero (linear mode, zero gain, centre at the origin).
// ----------------------------------------------------------------------------
`include "radial_bias_correction_macros.svh"

module radial_bias_correction (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rbc_pix_if.sink   i_pix,
    rbc_res_if.source o_res,
    rbc_cfg_if.sink   i_cfg
);

    logic signed [rbc_pkg::GAIN_W-1:0]   r_gain;
    rbc_pkg::t_mode                      r_mode;
    logic [rbc_pkg::COORD_BITS-1:0]      r_ccol;
    logic [rbc_pkg::COORD_BITS-1:0]      r_crow;

    logic                 w_en;
    logic                 w_dist_vld;
    rbc_pkg::t_dist_item  w_dist_item;
    logic                 w_root_vld;
    rbc_pkg::t_root_item  w_root_item;
    logic                 w_out_vld;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= '0;
            r_mode <= rbc_pkg::MODE_LINEAR;
            r_ccol <= '0;
            r_crow <= '0;
        end else if (i_cfg.valid) begin
            case (rbc_pkg::t_reg_idx'(i_cfg.index))
                rbc_pkg::REG_GAIN: begin
                    r_gain <= signed'(i_cfg.data[rbc_pkg::GAIN_W-1:0]);
                end
                rbc_pkg::REG_MODE: begin
                    r_mode <= rbc_pkg::t_mode'(i_cfg.data[0]);
                end
                rbc_pkg::REG_CCOL: begin
                    r_ccol <= i_cfg.data[rbc_pkg::COORD_BITS-1:0];
                end
                rbc_pkg::REG_CROW: begin
                    r_crow <= i_cfg.data[rbc_pkg::COORD_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Every stage advances unless the output register holds a pixel not yet taken.
    assign w_en        = !w_out_vld || o_res.ready;
    assign i_pix.ready = w_en;
    assign o_res.valid = w_out_vld;

    rbc_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_pix.valid),
        .i_pix   (i_pix.pixel_in),
        .i_col   (i_pix.col),
        .i_row   (i_pix.row),
        .i_ccol  (r_ccol),
        .i_crow  (r_crow),
        .o_vld   (w_dist_vld),
        .o_item  (w_dist_item)
    );

    rbc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_dist_vld),
        .i_item  (w_dist_item),
        .o_vld   (w_root_vld),
        .o_item  (w_root_item)
    );

    rbc_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_root_vld),
        .i_item  (w_root_item),
        .i_gain  (r_gain),
        .i_mode  (r_mode),
        .o_vld   (w_out_vld),
        .o_pixel (o_res.pixel_out),
        .o_clip  (o_res.clipped)
    );

    `RBC_ASSERT(a_stall_blocks_input, i_clk, i_rst_n, (o_res.valid && !o_res.ready) |-> !i_pix.ready, "input taken while the output is stalled")
    `RBC_ASSERT_NR(a_reset_empties, i_clk, !i_rst_n |=> !o_res.valid, "output valid right after reset")

endmodule

@@ src/rbc_dist.sv @@
// ----------------------------------------------------------------------------
// Radial bias correction distance stages
// Three register stages: absolute offsets, squares, squared distance.
// ----------------------------------------------------------------------------
`include "radial_bias_correction_macros.svh"

module rbc_dist (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_vld,
    input  logic [rbc_pkg::PIX_W-1:0]      i_pix,
    input  logic [rbc_pkg::COORD_BITS-1:0] i_col,
    input  logic [rbc_pkg::COORD_BITS-1:0] i_row,
    input  logic [rbc_pkg::COORD_BITS-1:0] i_ccol,
    input  logic [rbc_pkg::COORD_BITS-1:0] i_crow,
    output logic                           o_vld,
    output rbc_pkg::t_dist_item            o_item
);

    logic [2:0]                       r_vld;
    logic [rbc_pkg::PIX_W-1:0]        r_pix1;
    logic [rbc_pkg::PIX_W-1:0]        r_pix2;
    logic [rbc_pkg::COORD_BITS-1:0]   r_dx;
    logic [rbc_pkg::COORD_BITS-1:0]   r_dy;
    logic [rbc_pkg::SQ_W-1:0]         r_sqx;
    logic [rbc_pkg::SQ_W-1:0]         r_sqy;
    rbc_pkg::t_dist_item              r_item;

    logic [rbc_pkg::COORD_BITS-1:0]   n_dx;
    logic [rbc_pkg::COORD_BITS-1:0]   n_dy;
    logic [rbc_pkg::SQ_W-1:0]         n_sqx;
    logic [rbc_pkg::SQ_W-1:0]         n_sqy;
    logic [rbc_pkg::D2_W-1:0]         n_d2;

    assign n_dx  = (i_col >= i_ccol) ? (i_col - i_ccol) : (i_ccol - i_col);
    assign n_dy  = (i_row >= i_crow) ? (i_row - i_crow) : (i_crow - i_row);
    assign n_sqx = rbc_pkg::SQ_W'(r_dx) * rbc_pkg::SQ_W'(r_dx);
    assign n_sqy = rbc_pkg::SQ_W'(r_dy) * rbc_pkg::SQ_W'(r_dy);
    assign n_d2  = rbc_pkg::D2_W'(r_sqx) + rbc_pkg::D2_W'(r_sqy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix1      <= i_pix;
            r_dx        <= n_dx;
            r_dy        <= n_dy;
            r_pix2      <= r_pix1;
            r_sqx       <= n_sqx;
            r_sqy       <= n_sqy;
            r_item.pix  <= r_pix2;
            r_item.d2   <= n_d2;
        end
    end

    assign o_vld  = r_vld[2];
    assign o_item = r_item;

    `RBC_ASSERT(a_d2_range, i_clk, i_rst_n, o_vld |-> (o_item.d2 <= rbc_pkg::D2_MAX), "squared distance out of range")

endmodule

@@ src/rbc_isqrt.sv @@
// ----------------------------------------------------------------------------
// Radial bias correction square root pipeline
// One radius bit per register stage, restoring digit-by-digit method.
// ----------------------------------------------------------------------------
`include "radial_bias_correction_macros.svh"

module rbc_isqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  rbc_pkg::t_dist_item i_item,
    output logic                o_vld,
    output rbc_pkg::t_root_item o_item
);

    localparam int ROOT_W = rbc_pkg::ROOT_W;
    localparam int REM_W  = rbc_pkg::REM_W;
    localparam int PAD_W  = rbc_pkg::PAD_W;
    localparam int CHK_W  = PAD_W + 2;

    logic                r_vld  [ROOT_W];
    rbc_pkg::t_dist_item r_item [ROOT_W];
    logic [ROOT_W-1:0]   r_q    [ROOT_W];
    logic [REM_W-1:0]    r_rem  [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        logic                w_vld_in;
        rbc_pkg::t_dist_item w_item_in;
        logic [ROOT_W-1:0]   w_q_in;
        logic [REM_W-1:0]    w_rem_in;
        logic [PAD_W-1:0]    w_pad;
        logic [1:0]          w_pair;
        logic [REM_W+1:0]    w_rn;
        logic [REM_W+1:0]    w_trial;
        logic                w_ge;
        logic [ROOT_W-1:0]   n_q;
        logic [REM_W-1:0]    n_rem;

        if (s == 0) begin : g_first
            assign w_vld_in  = i_vld;
            assign w_item_in = i_item;
            assign w_q_in    = '0;
            assign w_rem_in  = '0;
        end else begin : g_next
            assign w_vld_in  = r_vld[s-1];
            assign w_item_in = r_item[s-1];
            assign w_q_in    = r_q[s-1];
            assign w_rem_in  = r_rem[s-1];
        end

        // The radicand is the squared distance with the fraction bits appended.
        assign w_pad   = PAD_W'({w_item_in.d2, {(2 * rbc_pkg::ROOT_FRAC){1'b0}}});
        assign w_pair  = w_pad[2 * (ROOT_W - 1 - s) +: 2];
        assign w_rn    = {w_rem_in, w_pair};
        assign w_trial = (REM_W + 2)'({w_q_in, 2'b01});
        assign w_ge    = (w_rn >= w_trial);
        assign n_q     = {w_q_in[ROOT_W-2:0], w_ge};
        assign n_rem   = w_ge ? REM_W'(w_rn - w_trial) : REM_W'(w_rn);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_item[s] <= w_item_in;
                r_q[s]    <= n_q;
                r_rem[s]  <= n_rem;
            end
        end
    end

    assign o_vld       = r_vld[ROOT_W-1];
    assign o_item.pix  = r_item[ROOT_W-1].pix;
    assign o_item.d2   = r_item[ROOT_W-1].d2;
    assign o_item.root = r_q[ROOT_W-1];

    // Bounds of the finished root, used only for checking.
    logic [CHK_W-1:0] w_chk_x;
    logic [CHK_W-1:0] w_chk_q1;
    logic [CHK_W-1:0] w_chk_lo;
    logic [CHK_W-1:0] w_chk_hi;

    assign w_chk_x  = CHK_W'({o_item.d2, {(2 * rbc_pkg::ROOT_FRAC){1'b0}}});
    assign w_chk_q1 = CHK_W'(o_item.root) + CHK_W'(1);
    assign w_chk_lo = CHK_W'(o_item.root) * CHK_W'(o_item.root);
    assign w_chk_hi = w_chk_q1 * w_chk_q1;

    `RBC_ASSERT(a_root_floor, i_clk, i_rst_n, o_vld |-> (w_chk_lo <= w_chk_x && w_chk_hi > w_chk_x), "radius is not the floor of the square root")

endmodule

@@ src/rbc_scale.sv @@
// ----------------------------------------------------------------------------
// Radial bias correction scaling stages
// Gain multiply, bias subtract, then round and saturate into the output register.
// ----------------------------------------------------------------------------
`include "radial_bias_correction_macros.svh"

module rbc_scale (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_vld,
    input  rbc_pkg::t_root_item                i_item,
    input  logic signed [rbc_pkg::GAIN_W-1:0]  i_gain,
    input  rbc_pkg::t_mode                     i_mode,
    output logic                               o_vld,
    output logic [rbc_pkg::PIX_W-1:0]          o_pixel,
    output logic                               o_clip
);

    localparam int PROD_W = rbc_pkg::PROD_W;
    localparam int V_W    = rbc_pkg::V_W;
    localparam int PIX_W  = rbc_pkg::PIX_W;

    logic [2:0]                r_vld;
    logic [PIX_W-1:0]          r_pix_a;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [V_W-1:0]     r_v;
    logic [PIX_W-1:0]          r_pix_out;
    logic                      r_clip;

    logic [rbc_pkg::OP_W-1:0]  n_op;
    logic signed [PROD_W-1:0]  w_gain_x;
    logic signed [PROD_W-1:0]  w_op_x;
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [V_W-1:0]     w_pix_sh;
    logic signed [V_W-1:0]     n_v;
    logic signed [V_W-1:0]     w_full;
    logic signed [V_W-1:0]     w_half;
    logic signed [V_W-1:0]     w_rnd;
    logic [PIX_W-1:0]          w_rnd_pix;
    logic                      w_neg;
    logic                      w_over;
    logic [PIX_W-1:0]          n_pix_out;
    logic                      n_clip;
    logic                      w_lin;

    assign w_lin = (i_mode == rbc_pkg::MODE_LINEAR);

    // Stage A: gain times radius or squared distance.
    assign n_op     = w_lin ? rbc_pkg::OP_W'(i_item.root) : rbc_pkg::OP_W'(i_item.d2);
    assign w_gain_x = PROD_W'(i_gain);
    assign w_op_x   = signed'(PROD_W'(n_op));
    assign n_prod   = w_gain_x * w_op_x;

    // Stage B: the pixel at the product's scale minus the bias.
    assign w_pix_sh = w_lin ? (V_W'(r_pix_a) << rbc_pkg::SH_LIN)
                            : (V_W'(r_pix_a) << rbc_pkg::SH_PAR);
    assign n_v      = w_pix_sh - V_W'(r_prod);

    // Stage C: round half up and saturate.
    assign w_full    = w_lin ? rbc_pkg::FULL_LIN : rbc_pkg::FULL_PAR;
    assign w_half    = w_lin ? rbc_pkg::HALF_LIN : rbc_pkg::HALF_PAR;
    assign w_rnd     = r_v + w_half;
    assign w_rnd_pix = w_lin ? w_rnd[rbc_pkg::SH_LIN +: PIX_W]
                             : w_rnd[rbc_pkg::SH_PAR +: PIX_W];
    assign w_neg     = r_v[V_W-1];
    assign w_over    = (r_v > w_full);

    always_comb begin
        n_pix_out = w_rnd_pix;
        n_clip    = 1'b0;
        if (w_neg) begin
            n_pix_out = '0;
            n_clip    = 1'b1;
        end else if (w_over) begin
            n_pix_out = rbc_pkg::PIX_MAX;
            n_clip    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix_a   <= i_item.pix;
            r_prod    <= n_prod;
            r_v       <= n_v;
            r_pix_out <= n_pix_out;
            r_clip    <= n_clip;
        end
    end

    assign o_vld   = r_vld[2];
    assign o_pixel = r_pix_out;
    assign o_clip  = r_clip;

    `RBC_ASSERT(a_clip_level, i_clk, i_rst_n, (o_vld && o_clip) |-> (o_pixel == '0 || o_pixel == rbc_pkg::PIX_MAX), "clipped pixel is not at a rail")

endmodule
